// ===== design/twd_pkg.sv =====
`timescale 1ns / 1ps

package twd_pkg;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_OTHER  = 2'd3
    } twd_func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_POOLFULL = 2'd2,
        ST_BADCHAR  = 2'd3
    } twd_status_t;

    // First character of the alphabet; link index is the byte minus this.
    localparam logic [7:0] CHAR_BASE = 8'd97;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] letter;
        logic       has_letter;
        logic       last;
    } twd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
    } twd_result_t;

endpackage

// ===== design/twd_ram.sv =====
`timescale 1ns / 1ps

module twd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 27648
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/twd_ctrl.sv =====
`timescale 1ns / 1ps

module twd_ctrl #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 27
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  twd_pkg::twd_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output twd_pkg::twd_result_t                  result,
    output logic                                  c_we,
    output logic [$clog2(NODES*ALPHABET)-1:0]     c_waddr,
    output logic [$clog2(NODES)-1:0]              c_wdata,
    output logic [$clog2(NODES*ALPHABET)-1:0]     c_raddr,
    input  logic [$clog2(NODES)-1:0]              c_rdata,
    output logic                                  m_we,
    output logic [$clog2(NODES)-1:0]              m_waddr,
    output logic                                  m_wdata,
    output logic [$clog2(NODES)-1:0]              m_raddr,
    input  logic                                  m_rdata
);

    import twd_pkg::*;

    localparam int TOTAL = NODES * ALPHABET;
    localparam int AW    = $clog2(TOTAL);
    localparam int NW    = $clog2(NODES);
    localparam int IW    = $clog2(ALPHABET);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FINAL,
        S_MARK
    } state_t;

    state_t       state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [NW-1:0] cursor_reg, cursor_next;
    logic [NW:0]   next_free_reg, next_free_next;
    logic          miss_reg, miss_next;
    logic          ovf_reg, ovf_next;
    logic          bad_reg, bad_next;
    logic [1:0]    func_reg, func_next;
    logic          last_reg, last_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          res_valid_reg, res_valid_next;
    twd_result_t   res_reg, res_next;

    logic [7:0]    diff;
    logic          letter_ok;
    logic [AW-1:0] slot_calc;
    logic          flag_any;
    logic          res_free;

    assign diff      = item.letter - CHAR_BASE;
    assign letter_ok = (item.letter >= CHAR_BASE) && (diff < 8'(ALPHABET));
    assign slot_calc = AW'(cursor_reg) * AW'(ALPHABET) + AW'(diff[IW-1:0]);
    assign flag_any  = miss_reg | ovf_reg | bad_reg;
    assign res_free  = !res_valid_reg || !result_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cursor_next    = cursor_reg;
        next_free_next = next_free_reg;
        miss_next      = miss_reg;
        ovf_next       = ovf_reg;
        bad_next       = bad_reg;
        func_next      = func_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        item_stall     = 1'b1;
        c_we           = 1'b0;
        c_waddr        = slot_reg;
        c_wdata        = next_free_reg[NW-1:0];
        c_raddr        = slot_calc;
        m_we           = 1'b0;
        m_waddr        = cursor_reg;
        m_wdata        = 1'b0;
        m_raddr        = cursor_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = clr_reg;
                c_wdata = '0;
                if (clr_reg < AW'(NODES))
                begin
                    m_we    = 1'b1;
                    m_waddr = clr_reg[NW-1:0];
                end
                if (clr_reg == AW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    func_next = item.func;
                    last_next = item.last;
                    slot_next = slot_calc;
                    if (item.has_letter && !flag_any && letter_ok)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        if (item.has_letter && !flag_any)
                        begin
                            bad_next = 1'b1;
                        end
                        state_next = item.last ? S_FINAL : S_IDLE;
                    end
                end
            end
            S_LOOKUP:
            begin
                // The child pointer read at accept time is available now.
                if (c_rdata == '0)
                begin
                    if (func_reg != FUNC_INSERT)
                    begin
                        miss_next = 1'b1;
                    end
                    else if (next_free_reg >= (NW+1)'(NODES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        c_we           = 1'b1;
                        cursor_next    = next_free_reg[NW-1:0];
                        next_free_next = next_free_reg + 1'b1;
                    end
                end
                else
                begin
                    cursor_next = c_rdata;
                end
                state_next = last_reg ? S_FINAL : S_IDLE;
            end
            S_FINAL:
            begin
                // The mark read issued here at the cursor returns in S_MARK.
                if (res_free)
                begin
                    if (flag_any || func_reg == FUNC_INSERT)
                    begin
                        res_valid_next = 1'b1;
                        res_next.found = 1'b0;
                        if (bad_reg)
                        begin
                            res_next.status = ST_BADCHAR;
                        end
                        else if (ovf_reg)
                        begin
                            res_next.status = ST_POOLFULL;
                        end
                        else if (miss_reg)
                        begin
                            res_next.status = ST_ABSENT;
                        end
                        else
                        begin
                            res_next.status = ST_OK;
                            res_next.found  = 1'b1;
                            m_we            = 1'b1;
                            m_wdata         = 1'b1;
                        end
                        cursor_next = '0;
                        miss_next   = 1'b0;
                        ovf_next    = 1'b0;
                        bad_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                res_valid_next  = 1'b1;
                res_next.status = ST_OK;
                res_next.found  = m_rdata;
                if (func_reg == FUNC_DELETE)
                begin
                    m_we = 1'b1;
                end
                cursor_next = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cursor_reg    <= '0;
            next_free_reg <= (NW+1)'(1);
            miss_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            func_reg      <= '0;
            last_reg      <= 1'b0;
            slot_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cursor_reg    <= cursor_next;
            next_free_reg <= next_free_next;
            miss_reg      <= miss_next;
            ovf_reg       <= ovf_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
            func_reg      <= func_next;
            last_reg      <= last_next;
            slot_reg      <= slot_next;
            res_reg       <= res_next;
        end
    end

endmodule

// ===== design/trie_word_dictionary_unit.sv =====
`timescale 1ns / 1ps
// Channel   Valid          Stall          Payload
// request   item_valid     item_stall     item   (func, letter, has_letter, last)
// result    result_valid   result_stall   result (status, found)
//
// A character item passes through S_IDLE and S_LOOKUP: the child pointer comes from a
// synchronous child-table read and the next character walks from it.
// A letterless or skipped item that is not last needs S_IDLE alone. A last item adds
// S_FINAL, then S_MARK when an error-free search, delete or code-3 word reads the mark.
// After reset both memories are cleared, one entry a cycle, with item_stall high.
// A waiting result holds only the end of the next word.

module trie_word_dictionary_unit #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 27
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  twd_pkg::twd_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output twd_pkg::twd_result_t result
);

    import twd_pkg::*;

    localparam int TOTAL = NODES * ALPHABET;
    localparam int AW    = $clog2(TOTAL);
    localparam int NW    = $clog2(NODES);

    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic [NW-1:0] c_wdata;
    logic [AW-1:0] c_raddr;
    logic [NW-1:0] c_rdata;
    logic          m_we;
    logic [NW-1:0] m_waddr;
    logic          m_wdata;
    logic [NW-1:0] m_raddr;
    logic          m_rdata;

    twd_ctrl #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .c_we         (c_we),
        .c_waddr      (c_waddr),
        .c_wdata      (c_wdata),
        .c_raddr      (c_raddr),
        .c_rdata      (c_rdata),
        .m_we         (m_we),
        .m_waddr      (m_waddr),
        .m_wdata      (m_wdata),
        .m_raddr      (m_raddr),
        .m_rdata      (m_rdata)
    );

    twd_ram #(
        .WIDTH (NW),
        .DEPTH (TOTAL)
    ) u_child (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    twd_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_mark (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

endmodule
